@@ src/poat_pkg.sv @@
// Package for the periodic/one-shot alarm table.
// It holds the transaction payload structs, the table entry layout and the operation and status codes.
// It has no dependencies.
`timescale 1ns / 1ps

package poat_pkg;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_ADD    = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [2:0] STAT_FIRED    = 3'd0;
  localparam logic [2:0] STAT_ADDED    = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_REMOVED  = 3'd3;
  localparam logic [2:0] STAT_MISSING  = 3'd4;

  // A tick stops scanning after this many fire results.
  localparam int          MAX_RESULTS = 16;
  localparam int          FIRE_CW     = 5;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_seconds;
    logic [31:0] job_id;
    logic        is_periodic;
    logic [31:0] interval_seconds;
    logic [31:0] at_time;
    logic        delete_after;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_id;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] ident;
    logic        periodic;
    logic [31:0] interval;
    logic [31:0] oneshot_time;
    logic        autodelete;
    logic        enabled;
    logic [32:0] due_time;
  } entry_t;

endpackage

@@ src/poat_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// It is used for the alarm table storage and has no dependencies.
`timescale 1ns / 1ps

module poat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/periodic_oneshot_alarm_table_top.sv @@
// Top level of the periodic/one-shot alarm table: sequencer, entry counter and output register.
// It depends on poat_pkg and instantiates poat_ram for the entry storage.
`timescale 1ns / 1ps

// The block keeps up to TABLE_SLOTS alarm entries in a compacted table held in one RAM
// with a registered read port. A transaction is taken only while the sequencer is idle,
// and a finished result may still wait in the output register at that time. An add writes
// the new entry at the end of the table, or finds the table full, and then presents its
// result. A remove compares the entries in turn, shifts the entries behind the deleted slot
// down one slot each, closes the search or the shift, and presents the result. A tick
// examines the entries in turn, shifts later entries down when an auto-delete one-shot
// fires, and closes the scan; when anything fired, it then presents the final fire result.
// The entries are stepped through the single RAM read port one at a time, and a stalled
// result channel holds the sequence. A tick with nothing due gives no result, and func
// value 3 is accepted and ignored.

module periodic_oneshot_alarm_table_top #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  poat_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output poat_pkg::out_t  out_data
);

  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);
  localparam logic [poat_pkg::FIRE_CW-1:0] MAX_FIRES =
    poat_pkg::FIRE_CW'(poat_pkg::MAX_RESULTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_SH_RD,
    S_SH_WR,
    S_EMIT
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [CW-1:0]                  idx_r, idx_nxt;
  logic [CW-1:0]                  sh_r, sh_nxt;
  logic [poat_pkg::FIRE_CW-1:0]   fires_r, fires_nxt;
  poat_pkg::in_t                  req_r, req_nxt;
  logic                           pend_valid_r, pend_valid_nxt;
  logic [31:0]                    pend_id_r, pend_id_nxt;
  logic [2:0]                     res_status_r, res_status_nxt;
  logic [31:0]                    res_id_r, res_id_nxt;
  logic                           out_valid_r, out_valid_nxt;
  poat_pkg::out_t                 out_data_r, out_data_nxt;

  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  poat_pkg::entry_t               wr_data;
  logic [AW-1:0]                  rd_addr;
  poat_pkg::entry_t               rd_data;

  logic                           out_free;
  logic                           due_ok;
  logic [32:0]                    now_ext;
  logic [32:0]                    resched;
  logic [CW-1:0]                  sh_inc;
  poat_pkg::entry_t               new_ent;

  poat_ram #(
    .WIDTH ($bits(poat_pkg::entry_t)),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign out_free = !out_valid_r || !out_stall;
  assign now_ext  = {1'b0, req_r.now_seconds};
  assign resched  = now_ext + {1'b0, rd_data.interval};
  assign due_ok   = rd_data.enabled && (rd_data.due_time != 33'd0) &&
                    (rd_data.due_time <= now_ext);
  assign sh_inc   = sh_r + 1'b1;

  // Entry built straight from the incoming add transaction.
  always_comb begin
    new_ent.ident        = in_data.job_id;
    new_ent.periodic     = in_data.is_periodic;
    new_ent.interval     = in_data.interval_seconds;
    new_ent.oneshot_time = in_data.at_time;
    new_ent.autodelete   = in_data.delete_after;
    new_ent.enabled      = 1'b1;
    if (in_data.is_periodic) begin
      new_ent.due_time = {1'b0, in_data.now_seconds} + {1'b0, in_data.interval_seconds};
    end else if (in_data.at_time > in_data.now_seconds) begin
      new_ent.due_time = {1'b0, in_data.at_time};
    end else begin
      new_ent.due_time = 33'd0;
      new_ent.enabled  = 1'b0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    sh_nxt         = sh_r;
    fires_nxt      = fires_r;
    req_nxt        = req_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r[AW-1:0];
    wr_data        = rd_data;
    rd_addr        = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt        = in_data;
          idx_nxt        = '0;
          fires_nxt      = '0;
          pend_valid_nxt = 1'b0;
          res_id_nxt     = in_data.job_id;
          case (in_data.func)
            poat_pkg::FUNC_TICK: begin
              state_nxt = S_RD;
            end
            poat_pkg::FUNC_ADD: begin
              if (count_r >= SLOTS_C) begin
                res_status_nxt = poat_pkg::STAT_FULL;
              end else begin
                wr_en          = 1'b1;
                wr_addr        = count_r[AW-1:0];
                wr_data        = new_ent;
                count_nxt      = count_r + 1'b1;
                res_status_nxt = poat_pkg::STAT_ADDED;
              end
              state_nxt = S_EMIT;
            end
            poat_pkg::FUNC_REMOVE: begin
              state_nxt = S_RD;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_RD: begin
        if (req_r.func == poat_pkg::FUNC_TICK) begin
          if ((idx_r >= count_r) || (fires_r >= MAX_FIRES)) begin
            // The held fire result is the final one of this tick.
            if (pend_valid_r) begin
              res_status_nxt = poat_pkg::STAT_FIRED;
              res_id_nxt     = pend_id_r;
              state_nxt      = S_EMIT;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            state_nxt = S_EV;
          end
        end else begin
          if (idx_r >= count_r) begin
            res_status_nxt = poat_pkg::STAT_MISSING;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_EV;
          end
        end
      end

      S_EV: begin
        if (req_r.func == poat_pkg::FUNC_REMOVE) begin
          if (rd_data.ident == req_r.job_id) begin
            sh_nxt    = idx_r;
            state_nxt = S_SH_RD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_RD;
          end
        end else if (!due_ok) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end else if (!pend_valid_r || out_free) begin
          // A fire result is held one step so that its last flag is known when it leaves.
          if (pend_valid_r) begin
            out_valid_nxt          = 1'b1;
            out_data_nxt.status    = poat_pkg::STAT_FIRED;
            out_data_nxt.result_id = pend_id_r;
            out_data_nxt.last      = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_id_nxt    = rd_data.ident;
          fires_nxt      = fires_r + 1'b1;
          if (rd_data.periodic) begin
            wr_en            = 1'b1;
            wr_data.due_time = resched;
            idx_nxt          = idx_r + 1'b1;
            state_nxt        = S_RD;
          end else if (rd_data.autodelete) begin
            sh_nxt    = idx_r;
            state_nxt = S_SH_RD;
          end else begin
            wr_en            = 1'b1;
            wr_data.enabled  = 1'b0;
            wr_data.due_time = 33'd0;
            idx_nxt          = idx_r + 1'b1;
            state_nxt        = S_RD;
          end
        end
      end

      S_SH_RD: begin
        rd_addr = sh_inc[AW-1:0];
        if (sh_inc < count_r) begin
          state_nxt = S_SH_WR;
        end else begin
          count_nxt = count_r - 1'b1;
          if (req_r.func == poat_pkg::FUNC_TICK) begin
            // The entry shifted into this slot is examined next.
            state_nxt = S_RD;
          end else begin
            res_status_nxt = poat_pkg::STAT_REMOVED;
            state_nxt      = S_EMIT;
          end
        end
      end

      S_SH_WR: begin
        rd_addr   = sh_inc[AW-1:0];
        wr_en     = 1'b1;
        wr_addr   = sh_r[AW-1:0];
        wr_data   = rd_data;
        sh_nxt    = sh_inc;
        state_nxt = S_SH_RD;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = res_status_r;
          out_data_nxt.result_id = res_id_r;
          out_data_nxt.last      = 1'b1;
          pend_valid_nxt         = 1'b0;
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    sh_r         <= sh_nxt;
    fires_r      <= fires_nxt;
    req_r        <= req_nxt;
    pend_id_r    <= pend_id_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

@@ src/poat_checker.sv @@
// Port-level checker for the alarm table top level, with the bind that attaches it.
// It depends on poat_pkg and on the port list of periodic_oneshot_alarm_table_top.
`timescale 1ns / 1ps

module poat_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input poat_pkg::in_t   in_data,
  input logic            out_valid,
  input logic            out_stall,
  input poat_pkg::out_t  out_data
);

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Add and remove always produce a result, so the block is busy right after taking one.
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_data.func == poat_pkg::FUNC_ADD || in_data.func == poat_pkg::FUNC_REMOVE)
    |=> in_stall)
    else $error("block idle after add or remove transaction");

  // Only fire results can be followed by more results of the same transaction.
  a_nonlast_fired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.status == poat_pkg::STAT_FIRED)
    else $error("non-final result is not a fire result");

  // While a non-final result is taken, the tick that caused it is still running.
  a_nonlast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |-> in_stall)
    else $error("block accepts input before the final result of a tick");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= poat_pkg::STAT_MISSING)
    else $error("result status out of range");

endmodule

bind periodic_oneshot_alarm_table_top poat_checker u_poat_checker (.*);
